FILE: design/rpn_stack_calculator_unit_assert.svh
// Assertion macros shared by the RPN calculator modules.
`ifndef RPN_STACK_CALCULATOR_UNIT_ASSERT_SVH
`define RPN_STACK_CALCULATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The condition holds at every clock edge out of reset.
`define RSC_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("rpn calculator check failed");
// The consequent holds in the same cycle as the antecedent.
`define RSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rpn calculator check failed");
// The consequent holds in the cycle after the antecedent.
`define RSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rpn calculator check failed");
`else
`define RSC_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define RSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RSC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: design/rpn_calc_pkg.sv
// Types, codes and helper functions shared by the RPN calculator modules.
package rpn_calc_pkg;

    // Operand stack geometry.
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Datapath geometry.
    localparam int DATA_W  = 32;
    localparam int STEP_W  = $clog2(DATA_W);
    localparam int DEPTH_W = 5;

    // Width mode register codes.
    localparam logic [1:0] WM_8  = 2'd0;
    localparam logic [1:0] WM_16 = 2'd1;
    localparam logic [1:0] WM_32 = 2'd2;

    // Token kinds.
    localparam logic [2:0] KIND_PUSH   = 3'd0;
    localparam logic [2:0] KIND_ADD    = 3'd1;
    localparam logic [2:0] KIND_SUB    = 3'd2;
    localparam logic [2:0] KIND_MUL    = 3'd3;
    localparam logic [2:0] KIND_FINISH = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FEW     = 3'd1;
    localparam logic [2:0] ST_ADD_OVF = 3'd2;
    localparam logic [2:0] ST_MUL_OVF = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;
    localparam logic [2:0] ST_EXTRA   = 3'd6;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] number;
    } token_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] top_value;
        logic [4:0]         depth;
        logic               done_res;
    } result_t;

    // Requests from the sequencer to the serial ALU.
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    // Status from the serial ALU back to the sequencer.
    typedef struct packed {
        logic done;
        logic ovf;
    } alu_sts_t;

    // Stack memory port controls.
    typedef struct packed {
        logic             we;
        logic             re;
        logic [PTR_W-1:0] waddr;
        logic [PTR_W-1:0] raddr;
    } stk_ctl_t;

    // Sign-extend the low bits of a stored word to the full data width.
    function automatic logic [DATA_W-1:0] sext_w(input logic [DATA_W-1:0] v,
                                                 input logic [1:0] wm);
        case (wm)
            WM_8:    sext_w = {{(DATA_W-8){v[7]}}, v[7:0]};
            WM_16:   sext_w = {{(DATA_W-16){v[15]}}, v[15:0]};
            default: sext_w = v;
        endcase
    endfunction

    // True when a 64-bit signed value fits the selected operand width.
    function automatic logic fits_w(input logic [2*DATA_W-1:0] p,
                                    input logic [1:0] wm);
        case (wm)
            WM_8:    fits_w = (&p[2*DATA_W-1:7]) | ~(|p[2*DATA_W-1:7]);
            WM_16:   fits_w = (&p[2*DATA_W-1:15]) | ~(|p[2*DATA_W-1:15]);
            default: fits_w = (&p[2*DATA_W-1:DATA_W-1]) | ~(|p[2*DATA_W-1:DATA_W-1]);
        endcase
    endfunction

endpackage

FILE: design/rpn_calc_stack.sv
// Operand stack memory with one write port and one registered read port.
module rpn_calc_stack
    import rpn_calc_pkg::*;
(
    input  logic              clk,
    input  stk_ctl_t          ctl,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [STACK_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write and read the stack entries.
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem_reg[ctl.waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem_reg[ctl.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/rpn_calc_alu.sv
// Serial ALU: bit-serial add and subtract, one multiplier bit per cycle multiply.
`include "rpn_stack_calculator_unit_assert.svh"
module rpn_calc_alu
    import rpn_calc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  alu_ctl_t          ctl,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    input  logic [1:0]        wmode,
    output alu_sts_t          sts,
    output logic [DATA_W-1:0] result
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    alu_op_t           op_reg, op_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] y_reg, y_next;
    logic [DATA_W:0]   acc_reg, acc_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              carry_reg, carry_next;

    logic              last_step;
    logic              yb;
    logic              sbit;
    logic              cout;
    logic [DATA_W:0]   addend;
    logic [DATA_W:0]   psum;

    assign last_step = (cnt_reg == STEP_W'(DATA_W - 1));

    // One bit of the operation per cycle.
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        carry_next = carry_reg;
        yb         = y_reg[0] ^ (op_reg == ALU_SUB);
        sbit       = x_reg[0] ^ yb ^ carry_reg;
        cout       = (x_reg[0] & yb) | (x_reg[0] & carry_reg) | (yb & carry_reg);
        addend     = y_reg[0] ? {x_reg[DATA_W-1], x_reg} : '0;
        psum       = acc_reg + (addend ^ {(DATA_W+1){last_step}})
                     + (DATA_W+1)'(last_step);
        if (ctl.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            op_next    = ctl.op;
            x_next     = a;
            y_next     = b;
            acc_next   = '0;
            res_next   = '0;
            carry_next = (ctl.op == ALU_SUB);
        end
        else if (busy_reg)
        begin
            case (op_reg)
                ALU_MUL:
                begin
                    // Add or, on the sign bit, subtract the multiplicand, then shift.
                    acc_next = {psum[DATA_W], psum[DATA_W:1]};
                    res_next = {psum[0], res_reg[DATA_W-1:1]};
                    y_next   = y_reg >> 1;
                end
                default:
                begin
                    // Full adder on the low bits; the sign of the wide sum goes to acc.
                    res_next   = {sbit, res_reg[DATA_W-1:1]};
                    x_next     = x_reg >> 1;
                    y_next     = y_reg >> 1;
                    carry_next = cout;
                    if (last_step)
                    begin
                        acc_next = {(DATA_W+1){x_reg[0] ^ yb ^ cout}};
                    end
                end
            endcase
            cnt_next = cnt_reg + STEP_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control and data registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            acc_reg   <= acc_next;
            res_reg   <= res_next;
            carry_reg <= carry_next;
        end
    end

    // Signed overflow of the exact add or multiply result against the operand width; subtract never reports it.
    assign sts.done = done_reg;
    assign sts.ovf  = (op_reg != ALU_SUB) &&
                      !fits_w({acc_reg[DATA_W-1:0], res_reg}, wmode);
    assign result   = res_reg;

    `RSC_ASSERT_IMP(a_no_start_busy, clk, rst_n, ctl.start, !busy_reg)
    `RSC_ASSERT_IMP(a_done_after_run, clk, rst_n, done_reg, $past(busy_reg))
    `RSC_ASSERT_NXT(a_busy_after_start, clk, rst_n, ctl.start, busy_reg)

endmodule

FILE: design/rpn_stack_calculator_unit.sv
// Top level of the RPN stack calculator: token sequencer, stack and serial ALU.
//
// Usage:
// - Tokens arrive on in_valid/in_ready/in_data; one transfer is one token.
// - Every token gives exactly one result on out_valid/out_ready/out_data.
// - cfg_valid/cfg_ready/cfg_data writes the width mode; cfg_ready is always
//   high and the write must come while no token is in flight.
// - Push, finish, unknown kinds and tokens that meet a sticky error, a full
//   stack or too few operands go through decode to the emit state, which loads
//   the result register; only then is the next token taken.
// - Add, subtract and multiply read the second operand from the stack memory
//   and then run 32 steps of the serial ALU, one bit per cycle; the result
//   loads in the emit state and only then is the next token taken.
// - The result register holds a result until it is taken; the sequencer
//   already works on the next token and stalls only when it must load a new
//   result while the previous one is still waiting.
// - Reset empties the stack, clears the sticky error, drops out_valid and
//   sets the width mode to 32 bits. The stack memory needs no clearing.
`include "rpn_stack_calculator_unit_assert.svh"
module rpn_stack_calculator_unit
    import rpn_calc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  token_t     in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_RD,
        ST_RUN,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        kind_reg, kind_next;
    logic [DATA_W-1:0] num_reg, num_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [2:0]        sticky_reg, sticky_next;
    logic [1:0]        wmode_reg, wmode_next;
    logic [2:0]        pend_status_reg, pend_status_next;
    logic [DATA_W-1:0] pend_value_reg, pend_value_next;
    logic              pend_done_reg, pend_done_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;

    stk_ctl_t          stk_ctl;
    logic [DATA_W-1:0] stk_wdata;
    logic [DATA_W-1:0] stk_rdata;
    alu_ctl_t          alu_ctl;
    alu_sts_t          alu_sts;
    logic [DATA_W-1:0] alu_res;
    logic [CNT_W-1:0]  below2;
    logic              slot_free;

    assign below2    = cnt_reg - CNT_W'(2);
    assign slot_free = !out_valid_reg || out_ready;

    // Stack memory.
    rpn_calc_stack u_stack (
        .clk   (clk),
        .ctl   (stk_ctl),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    // Serial arithmetic unit.
    rpn_calc_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .a      (sext_w(stk_rdata, wmode_reg)),
        .b      (sext_w(top_reg, wmode_reg)),
        .wmode  (wmode_reg),
        .sts    (alu_sts),
        .result (alu_res)
    );

    // Token sequencer.
    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        num_next         = num_reg;
        cnt_next         = cnt_reg;
        top_next         = top_reg;
        sticky_next      = sticky_reg;
        wmode_next       = wmode_reg;
        pend_status_next = pend_status_reg;
        pend_value_next  = pend_value_reg;
        pend_done_next   = pend_done_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        stk_ctl.we       = 1'b0;
        stk_ctl.re       = 1'b0;
        stk_ctl.waddr    = below2[PTR_W-1:0];
        stk_ctl.raddr    = below2[PTR_W-1:0];
        stk_wdata        = (state_reg == ST_DEC) ? num_reg : alu_res;
        alu_ctl.start    = 1'b0;
        alu_ctl.op       = ALU_ADD;

        // A waiting result leaves once the receiver takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Width mode writes.
        if (cfg_valid)
        begin
            wmode_next = cfg_data;
        end

        case (kind_reg)
            KIND_SUB: alu_ctl.op = ALU_SUB;
            KIND_MUL: alu_ctl.op = ALU_MUL;
            default:  alu_ctl.op = ALU_ADD;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = in_data.kind;
                    num_next   = in_data.number;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                pend_done_next = 1'b0;
                state_next     = ST_EMIT;
                if (kind_reg == KIND_FINISH)
                begin
                    // Report the single value or the error status, then clear the stack and error.
                    pend_done_next  = 1'b1;
                    pend_value_next = '0;
                    if (sticky_reg != ST_OK)
                    begin
                        pend_status_next = sticky_reg;
                    end
                    else if (cnt_reg == '0)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else if (cnt_reg > CNT_W'(1))
                    begin
                        pend_status_next = ST_EXTRA;
                    end
                    else
                    begin
                        pend_status_next = ST_OK;
                        pend_value_next  = sext_w(top_reg, wmode_reg);
                    end
                    cnt_next    = '0;
                    sticky_next = ST_OK;
                end
                else if (sticky_reg == ST_OK)
                begin
                    case (kind_reg)
                        KIND_PUSH:
                        begin
                            if (cnt_reg >= CNT_W'(STACK_DEPTH))
                            begin
                                sticky_next = ST_FULL;
                            end
                            else
                            begin
                                stk_ctl.we    = 1'b1;
                                stk_ctl.waddr = cnt_reg[PTR_W-1:0];
                                top_next      = num_reg;
                                cnt_next      = cnt_reg + CNT_W'(1);
                            end
                        end
                        KIND_ADD, KIND_SUB, KIND_MUL:
                        begin
                            if (cnt_reg < CNT_W'(2))
                            begin
                                sticky_next = ST_FEW;
                            end
                            else
                            begin
                                stk_ctl.re = 1'b1;
                                state_next = ST_RD;
                            end
                        end
                        default:
                        begin
                            // Unknown kinds change nothing.
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                alu_ctl.start = 1'b1;
                state_next    = ST_RUN;
            end
            ST_RUN:
            begin
                if (alu_sts.done)
                begin
                    if (alu_sts.ovf)
                    begin
                        sticky_next = (kind_reg == KIND_MUL) ? ST_MUL_OVF : ST_ADD_OVF;
                    end
                    else
                    begin
                        // The result replaces the two operands.
                        stk_ctl.we = 1'b1;
                        top_next   = alu_res;
                        cnt_next   = cnt_reg - CNT_W'(1);
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.depth    = DEPTH_W'(cnt_reg);
                    out_data_next.done_res = pend_done_reg;
                    if (pend_done_reg)
                    begin
                        out_data_next.status    = pend_status_reg;
                        out_data_next.top_value = pend_value_reg;
                    end
                    else
                    begin
                        out_data_next.status    = sticky_reg;
                        out_data_next.top_value = (cnt_reg != '0) ?
                                                  sext_w(top_reg, wmode_reg) : '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, stack bookkeeping and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sticky_reg    <= ST_OK;
            wmode_reg     <= WM_32;
            pend_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            num_reg         <= num_next;
            cnt_reg         <= cnt_next;
            top_reg         <= top_next;
            sticky_reg      <= sticky_next;
            wmode_reg       <= wmode_next;
            pend_status_reg <= pend_status_next;
            pend_value_reg  <= pend_value_next;
            pend_done_reg   <= pend_done_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    `RSC_ASSERT_ALWAYS(a_count_bound, clk, rst_n, cnt_reg <= CNT_W'(STACK_DEPTH))
    `RSC_ASSERT_IMP(a_done_in_run, clk, rst_n, alu_sts.done, state_reg == ST_RUN)
    `RSC_ASSERT_IMP(a_pop_two, clk, rst_n, alu_sts.done && !alu_sts.ovf, cnt_reg >= CNT_W'(2))

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the RPN stack calculator: directed and random token streams.
module tb_top;
    import rpn_calc_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT = 800000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 40;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    token_t     in_data;
    logic       out_valid;
    logic       out_ready;
    result_t    out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;

    // Predicted state of the calculator.
    logic [31:0] calc_stack [STACK_DEPTH];
    int          calc_count = 0;
    logic [2:0]  calc_error = ST_OK;
    logic [1:0]  calc_width_mode = WM_32;

    result_t     expected_q [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          phase_items = 0;
    int          gap_burst_left = 0;
    int          ready_hold = 0;

    rpn_stack_calculator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Operand width in bits for a width mode; the unused code acts as 32 bits.
    function automatic int operand_bits(logic [1:0] wm);
        case (wm)
            WM_8:    return 8;
            WM_16:   return 16;
            default: return 32;
        endcase
    endfunction

    // Low width bits of a stack word, sign-extended.
    function automatic longint sign_ext(logic [31:0] v, logic [1:0] wm);
        case (wm)
            WM_8:    return longint'($signed(v[7:0]));
            WM_16:   return longint'($signed(v[15:0]));
            default: return longint'($signed(v));
        endcase
    endfunction

    // True when an exact result fits the signed range of the width.
    function automatic bit fits_width(longint v, logic [1:0] wm);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (operand_bits(wm) - 1)) - 1;
        lo = -hi - 1;
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic [31:0] stack_top();
        if (calc_count == 0)
            return 32'd0;
        return 32'(sign_ext(calc_stack[calc_count - 1], calc_width_mode));
    endfunction

    // Applies one token to the predicted state and returns the result it should give.
    function automatic result_t predict_token(token_t t);
        result_t r;
        longint  a;
        longint  b;
        longint  x;
        bit      ok;
        r = '0;
        x = 0;
        if (t.kind == KIND_FINISH)
        begin
            r.done_res = 1'b1;
            if (calc_error != ST_OK)
                r.status = calc_error;
            else if (calc_count == 0)
                r.status = ST_EMPTY;
            else if (calc_count > 1)
                r.status = ST_EXTRA;
            else
            begin
                r.status    = ST_OK;
                r.top_value = stack_top();
            end
            calc_count = 0;
            calc_error = ST_OK;
        end
        else
        begin
            // A sticky error or an unknown kind leaves the stack alone.
            if (calc_error == ST_OK && t.kind <= KIND_MUL)
            begin
                if (t.kind == KIND_PUSH)
                begin
                    if (calc_count >= STACK_DEPTH)
                        calc_error = ST_FULL;
                    else
                    begin
                        calc_stack[calc_count] = t.number;
                        calc_count++;
                    end
                end
                else if (calc_count < 2)
                    calc_error = ST_FEW;
                else
                begin
                    a  = sign_ext(calc_stack[calc_count - 2], calc_width_mode);
                    b  = sign_ext(calc_stack[calc_count - 1], calc_width_mode);
                    ok = 1'b1;
                    case (t.kind)
                        KIND_ADD:
                        begin
                            x = a + b;
                            if (!fits_width(x, calc_width_mode))
                            begin
                                ok = 1'b0;
                                calc_error = ST_ADD_OVF;
                            end
                        end
                        KIND_SUB:
                            x = a - b;
                        default:
                        begin
                            x = a * b;
                            if (!fits_width(x, calc_width_mode))
                            begin
                                ok = 1'b0;
                                calc_error = ST_MUL_OVF;
                            end
                        end
                    endcase
                    if (ok)
                    begin
                        calc_count--;
                        calc_stack[calc_count - 1] = x[31:0];
                    end
                end
            end
            r.status    = calc_error;
            r.top_value = stack_top();
        end
        r.depth = calc_count[4:0];
        return r;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Idle cycles before a token: mostly none or short, a few long, some bursts with none.
    function automatic int pick_gap();
        int r;
        if (gap_burst_left > 0)
        begin
            gap_burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            gap_burst_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    // Small or random number; extremes of the width keep random upper bits.
    function automatic logic [31:0] random_number(logic [1:0] wm);
        logic [31:0] v;
        logic [31:0] mask;
        mask = (operand_bits(wm) == 32) ? 32'hffff_ffff : ((32'd1 << operand_bits(wm)) - 1);
        v = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 16)) - 8;
            4:          v = (v & ~mask) | (mask >> 1);
            5:          v = (v & ~mask) | ((mask >> 1) + 1);
            6:          v = (v & ~mask) | ($urandom_range(0, 1) ? mask : 32'd0);
            default:    v = v;
        endcase
        return v;
    endfunction

    // Sends one token and records its expected result at the transfer.
    task automatic send_token(logic [2:0] kind, logic [31:0] number);
        token_t t;
        int     gap;
        t.kind   = kind;
        t.number = number;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (!in_ready);
        expected_q.push_back(predict_token(t));
        phase_items++;
    endtask

    // Stops sending and waits until every expected result has come.
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_width_mode(logic [1:0] wm);
        wait_drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= wm;
        do
            @(posedge clk);
        while (!cfg_ready);
        calc_width_mode = wm;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
                note_failure($sformatf("Unexpected result: status %0d top %0d depth %0d done %0b",
                    out_data.status, out_data.top_value, out_data.depth, out_data.done_res));
            else
            begin
                want = expected_q.pop_front();
                if (out_data.status !== want.status || out_data.top_value !== want.top_value ||
                    out_data.depth !== want.depth || out_data.done_res !== want.done_res)
                    note_failure($sformatf(
                        "Mismatch: status %0d/%0d top %0d/%0d depth %0d/%0d done %0b/%0b (exp/act)",
                        want.status, out_data.status, want.top_value, out_data.top_value,
                        want.depth, out_data.depth, want.done_res, out_data.done_res));
            end
        end
    end

    // Receiver readiness: short stalls, a few long ones, and stretches with none.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
                ready_hold--;
            else if (out_ready)
            begin
                out_ready <= 1'b0;
                case ($urandom_range(0, 19))
                    0:       ready_hold = $urandom_range(30, 80);
                    1, 2, 3: ready_hold = $urandom_range(3, 10);
                    default: ready_hold = $urandom_range(0, 2);
                endcase
            end
            else
            begin
                out_ready <= 1'b1;
                ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                         : $urandom_range(0, 5);
            end
        end
    end

    // Finish on an empty stack right after reset, at the reset width.
    task automatic test_empty_finish();
        send_token(KIND_FINISH, $urandom());
    endtask

    // Every operation in one expression: (7 - -3) * 5 + 2.
    task automatic test_each_operation();
        send_token(KIND_PUSH, 7);
        send_token(KIND_PUSH, -3);
        send_token(KIND_SUB, $urandom());
        send_token(KIND_PUSH, 5);
        send_token(KIND_MUL, $urandom());
        send_token(KIND_PUSH, 2);
        send_token(KIND_ADD, $urandom());
        send_token(KIND_FINISH, 0);
    endtask

    // Unknown kinds report the current state; too few operands sets a sticky error.
    task automatic test_too_few_and_unknown();
        send_token(KIND_PUSH, 9);
        send_token(3'd5, $urandom());
        send_token(3'd6, $urandom());
        send_token(KIND_ADD, 0);
        send_token(3'd7, $urandom());
        send_token(KIND_FINISH, 0);
    endtask

    task automatic test_add_overflow();
        send_token(KIND_PUSH, 32'h7fff_ffff);
        send_token(KIND_PUSH, 1);
        send_token(KIND_ADD, 0);
        send_token(KIND_FINISH, 0);
    endtask

    task automatic test_mul_overflow();
        send_token(KIND_PUSH, 32'h8000_0000);
        send_token(KIND_PUSH, 32'hffff_ffff);
        send_token(KIND_MUL, 0);
        send_token(KIND_FINISH, 0);
    endtask

    // Subtract wraps without error; two values left at finish is an error.
    task automatic test_sub_wrap_extra_values();
        send_token(KIND_PUSH, 32'h8000_0000);
        send_token(KIND_PUSH, 1);
        send_token(KIND_SUB, 0);
        send_token(KIND_PUSH, 0);
        send_token(KIND_FINISH, 0);
    endtask

    // One random expression: mostly well formed, some deep stacks, some noise.
    task automatic send_expression(logic [1:0] wm);
        int shape;
        int operands;
        int pushed;
        int live;
        shape = $urandom_range(0, 99);
        if (shape < 12)
        begin
            repeat ($urandom_range(1, 6))
                send_token(3'($urandom_range(0, 7)), $urandom());
            if ($urandom_range(0, 1))
                send_token(KIND_FINISH, $urandom());
        end
        else if (shape < 22)
        begin
            // Fill the stack to near or past its depth, then fold some of it.
            repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 1))
                send_token(KIND_PUSH, random_number(wm));
            repeat ($urandom_range(0, STACK_DEPTH))
                send_token(3'($urandom_range(KIND_ADD, KIND_MUL)), $urandom());
            send_token(KIND_FINISH, $urandom());
        end
        else
        begin
            operands = $urandom_range(1, 6);
            pushed   = 0;
            live     = 0;
            while (pushed < operands || live > 1)
            begin
                if (pushed < operands && (live < 2 || $urandom_range(0, 1)))
                begin
                    send_token(KIND_PUSH, random_number(wm));
                    pushed++;
                    live++;
                end
                else
                begin
                    send_token(3'($urandom_range(KIND_ADD, KIND_MUL)), $urandom());
                    live--;
                end
            end
            send_token(KIND_FINISH, $urandom());
        end
    endtask

    // Random expressions under one width mode.
    task automatic test_random_width(logic [1:0] wm, int item_count);
        write_width_mode(wm);
        phase_items = 0;
        while (phase_items < item_count)
        begin
            send_expression(wm);
            // Now and then hold off until the block has answered everything.
            if ($urandom_range(0, 49) == 0)
                wait_drain();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = WM_32;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_finish();
        test_each_operation();
        test_too_few_and_unknown();
        test_add_overflow();
        test_mul_overflow();
        test_sub_wrap_extra_values();

        test_random_width(WM_8, 160);
        test_random_width(WM_16, 160);
        test_random_width(2'd3, 100);
        test_random_width(WM_32, 160);
        test_random_width(WM_8, 150);

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/rpn_calc_pkg.sv
design/rpn_calc_stack.sv
design/rpn_calc_alu.sv
design/rpn_stack_calculator_unit.sv
dv/tb_top.sv
